>>> hw/rtl/sliding_window_peak_count_max_top_assert.svh
// Assertion macros shared by the checker of the peak count block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SLIDING_WINDOW_PEAK_COUNT_MAX_TOP_ASSERT_SVH
`define SLIDING_WINDOW_PEAK_COUNT_MAX_TOP_ASSERT_SVH

// Hold: once vld is up and rdy is down, vld stays and data holds.
`define SWPC_ASSERT_HOLD(label, vld, rdy, data) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(data))) \
        else $error("swpc: stalled channel dropped or changed its item");

// Next-cycle check: the consequent holds in the cycle after the antecedent.
`define SWPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) \
        else $error("swpc: next-cycle property failed");

`endif

>>> hw/rtl/swpc_pkg.sv
`default_nettype none

package swpc_pkg;

    localparam int HEIGHT_BITS = 32;
    localparam int COUNT_BITS  = 12;
    localparam int START_BITS  = 21;
    localparam int WLEN_BITS   = 13;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 13'd3;

    // Register word index, taken from paddr above the byte offset
    localparam logic [PADDR_BITS-3:0] REG_WINDOW_LEN = 1'b0;

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] height;
        logic                   last;
    } swpc_in_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] best_parts;
        logic [START_BITS-1:0] best_start;
    } swpc_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/swpc_ram.sv
`default_nettype none

module swpc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_peak_count_max_top.sv
// Channel  | Direction | Handshake               | Payload
// in       | input     | in_valid / in_ready     | in_data  (height, last)
// out      | output    | out_valid / out_ready   | out_data (best_parts, best_start)
// cfg      | input     | APB psel/penable/pwrite | window_len at byte address 0
//
// One item per cycle unless a register write or a stalled result holds the input; an item
// sits in the input register; a last item's result is registered in the output register.
// The flag memory read port is prefetched one item ahead, so the first item after a
// configuration write waits while the prefetch is redone.
// Reset is asynchronous, active low; the flag memory needs no clearing pass, and the
// sequence state clears on every last item. A stalled result holds only last items.
`default_nettype none

module sliding_window_peak_count_max_top
    import swpc_pkg::*;
#(
    parameter int MAX_WINDOW  = 4096,
    parameter int MAX_LENGTH  = 1048576,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire swpc_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output swpc_out_t                  out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic      [PDATA_BITS-1:0] prdata,
    output logic                       pready
);

    // Index width holds MAX_LENGTH itself (saturation value)
    localparam int IW = $clog2(MAX_LENGTH + 1);
    localparam int KW = $clog2(MAX_WINDOW + 1);
    // Compare width: covers index, window and register, plus a sign margin
    localparam int CW0 = (IW > KW) ? IW : KW;
    localparam int CW  = ((CW0 > WLEN_BITS) ? CW0 : WLEN_BITS) + 1;
    // Flag slots: a power of two no smaller than the longest window
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int DEPTH = 1 << AW;

    // Configuration
    logic [WLEN_BITS-1:0] wlen_reg;
    logic                 cfg_wr;
    logic                 cfg_wr_d_reg;

    // Input register
    logic                   in_vld_reg;
    logic [SAMPLE_BITS-1:0] height_reg;
    logic                   last_reg;

    // Sequence state
    logic [SAMPLE_BITS-1:0] prev_reg,       prev_next;
    logic [SAMPLE_BITS-1:0] prev_prev_reg,  prev_prev_next;
    logic [IW-1:0]          idx_reg,        idx_next;
    logic [COUNT_BITS-1:0]  win_peaks_reg,  win_peaks_next;
    logic [COUNT_BITS-1:0]  best_peaks_reg, best_peaks_next;
    logic [IW-1:0]          best_start_reg, best_start_next;

    // Output register
    logic      out_vld_reg, out_vld_next;
    swpc_out_t out_reg,     out_next;

    // Flag memory
    logic          flag_we;
    logic [AW-1:0] flag_waddr;
    logic          flag_wdata;
    logic [AW-1:0] flag_raddr;
    logic          flag_rdata;
    logic          byp_vld_reg;
    logic          byp_data_reg;
    logic          flag_old;

    // Step datapath
    logic                  proceed;
    logic                  active;
    logic                  peak;
    logic                  idx_ge_2;
    logic [CW-1:0]         wl_c;
    logic [CW-1:0]         k_c;
    logic [CW-1:0]         idx_c;
    logic [CW-1:0]         idx_inc_c;
    logic [CW-1:0]         wpos_c;
    logic [CW-1:0]         rpos_c;
    logic [COUNT_BITS-1:0] wp_add;
    logic [COUNT_BITS-1:0] wp_sub;

    //------------------------------------------------------------------
    // APB register port: one register, always ready
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[PADDR_BITS-1:2] == REG_WINDOW_LEN);

    always_comb
    begin
        if (paddr[PADDR_BITS-1:2] == REG_WINDOW_LEN)
        begin
            prdata = PDATA_BITS'(wlen_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    //------------------------------------------------------------------
    // Handshake: advance when the prefetched flag is current and a last
    // item has room in the output register
    //------------------------------------------------------------------
    assign proceed  = in_vld_reg && !cfg_wr_d_reg
                      && (!last_reg || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || proceed;

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // Flag of the position leaving the window; bypass a same-address write
    assign flag_old = byp_vld_reg ? byp_data_reg : flag_rdata;

    //------------------------------------------------------------------
    // Step logic
    //------------------------------------------------------------------
    always_comb
    begin
        // Clamp the window length to 3..MAX_WINDOW
        wl_c = CW'(wlen_reg);
        priority if (wl_c < CW'(3))
        begin
            k_c = CW'(3);
        end
        else if (wl_c > CW'(MAX_WINDOW))
        begin
            k_c = CW'(MAX_WINDOW);
        end
        else
        begin
            k_c = wl_c;
        end

        idx_c     = CW'(idx_reg);
        idx_inc_c = idx_c + CW'(1);
        wpos_c    = idx_c - CW'(1);
        active    = idx_reg < IW'(MAX_LENGTH);
        idx_ge_2  = idx_reg >= IW'(2);
        peak      = (prev_prev_reg < prev_reg) && (prev_reg > height_reg);

        wp_add = win_peaks_reg + ((idx_ge_2 && peak) ? COUNT_BITS'(1) : COUNT_BITS'(0));
        wp_sub = (idx_c >= k_c)
                 ? wp_add - (flag_old ? COUNT_BITS'(1) : COUNT_BITS'(0))
                 : wp_add;

        // Hold by default
        prev_next       = prev_reg;
        prev_prev_next  = prev_prev_reg;
        idx_next        = idx_reg;
        win_peaks_next  = win_peaks_reg;
        best_peaks_next = best_peaks_reg;
        best_start_next = best_start_reg;
        out_vld_next    = out_vld_reg && !out_ready;
        out_next        = out_reg;

        flag_we    = proceed && active && idx_ge_2;
        flag_waddr = wpos_c[AW-1:0];
        flag_wdata = peak;

        if (proceed && active)
        begin
            win_peaks_next = wp_sub;
            if (idx_inc_c == k_c)
            begin
                best_peaks_next = wp_sub;
                best_start_next = '0;
            end
            else if ((idx_inc_c > k_c) && (wp_sub > best_peaks_reg))
            begin
                best_peaks_next = wp_sub;
                best_start_next = IW'(idx_inc_c - k_c);
            end
            prev_prev_next = prev_reg;
            prev_next      = height_reg;
            idx_next       = idx_reg + IW'(1);
        end

        if (proceed && last_reg)
        begin
            out_vld_next = 1'b1;
            if (CW'(idx_next) < k_c)
            begin
                // Sequence shorter than the window
                out_next.best_parts = win_peaks_next + COUNT_BITS'(1);
                out_next.best_start = START_BITS'(1);
            end
            else
            begin
                out_next.best_parts = best_peaks_next + COUNT_BITS'(1);
                out_next.best_start = START_BITS'(best_start_next + IW'(1));
            end
            // Drop the sequence state
            prev_next       = '0;
            prev_prev_next  = '0;
            idx_next        = '0;
            win_peaks_next  = '0;
            best_peaks_next = '0;
            best_start_next = '0;
        end

        // Prefetch the flag the next item will drop from its window
        rpos_c     = CW'(idx_next) + CW'(1) - k_c;
        flag_raddr = rpos_c[AW-1:0];
    end

    //------------------------------------------------------------------
    // Registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg       <= WLEN_RESET;
            cfg_wr_d_reg   <= 1'b0;
            in_vld_reg     <= 1'b0;
            prev_reg       <= '0;
            prev_prev_reg  <= '0;
            idx_reg        <= '0;
            win_peaks_reg  <= '0;
            best_peaks_reg <= '0;
            best_start_reg <= '0;
            out_vld_reg    <= 1'b0;
            byp_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                wlen_reg <= pwdata[WLEN_BITS-1:0];
            end
            cfg_wr_d_reg <= cfg_wr;

            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end

            prev_reg       <= prev_next;
            prev_prev_reg  <= prev_prev_next;
            idx_reg        <= idx_next;
            win_peaks_reg  <= win_peaks_next;
            best_peaks_reg <= best_peaks_next;
            best_start_reg <= best_start_next;
            out_vld_reg    <= out_vld_next;
            byp_vld_reg    <= flag_we && (flag_waddr == flag_raddr);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            height_reg <= SAMPLE_BITS'(in_data.height);
            last_reg   <= in_data.last;
        end
        out_reg      <= out_next;
        byp_data_reg <= flag_wdata;
    end

    swpc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/swpc_checker.sv
`default_nettype none

`include "sliding_window_peak_count_max_top_assert.svh"

module swpc_checker
    import swpc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire swpc_in_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire swpc_out_t out_data,
    input wire logic      psel,
    input wire logic      penable,
    input wire logic      pwrite
);

    logic cfg_write;
    logic plain_take;

    assign cfg_write  = psel && penable && pwrite;
    assign plain_take = in_valid && in_ready && !in_data.last && !cfg_write;

    // A stalled result keeps its item
    `SWPC_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_data)

    // An empty input side stays ready
    `SWPC_ASSERT_NEXT(a_idle_ready, (in_ready && !in_valid), in_ready)

    // A non-last item never blocks the next one, absent a register write
    `SWPC_ASSERT_NEXT(a_flow_ready, plain_take, in_ready)

endmodule

bind sliding_window_peak_count_max_top swpc_checker u_swpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite)
);

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
    import swpc_pkg::*;

    localparam int MAX_WINDOW   = 4096;
    localparam int MAX_LENGTH   = 1048576;
    localparam int SAMPLE_BITS  = 32;
    localparam int FLAG_AW      = $clog2(MAX_WINDOW);
    localparam int CYCLE_LIMIT  = 200000;
    // Covers the input and output registers plus the prefetch redo after a register write.
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 530;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    swpc_in_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    swpc_out_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    sliding_window_peak_count_max_top #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_LENGTH (MAX_LENGTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Peak-count predictor state: a private copy of the block's sequence
    // state and of its window length register.
    // ------------------------------------------------------------------
    logic [WLEN_BITS-1:0]   wlen_model;
    logic [HEIGHT_BITS-1:0] hist1;        // sample just before the current one
    logic [HEIGHT_BITS-1:0] hist2;        // sample two back
    int unsigned            n_taken;      // samples taken, stops at MAX_LENGTH
    bit [MAX_WINDOW-1:0]    peak_flags;   // slot = position mod MAX_WINDOW
    logic [COUNT_BITS-1:0]  win_count;    // peaks inside the window ending now
    logic [COUNT_BITS-1:0]  top_count;    // best window so far
    logic [19:0]            top_start;    // its 0-based start

    swpc_out_t   expected_best[$];
    int unsigned err_count;
    int unsigned cycle_count;
    int unsigned items_sent;

    // Sender burst control and receiver stall control.
    bit          tx_gaps;
    int unsigned burst_left;
    bit          rx_stalls;
    int unsigned rx_hold;
    int unsigned rx_run;
    bit          rx_phase;

    swpc_out_t   want;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stop a hung run; the limit sits well above the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Clear the per-sequence state, as the block does after each last item.
    task automatic clear_sequence();
        hist1      = '0;
        hist2      = '0;
        n_taken    = 0;
        peak_flags = '0;
        win_count  = '0;
        top_count  = '0;
        top_start  = '0;
    endtask

    // Advance the predictor by one accepted item; queue a result on a last item.
    task automatic track_peaks(input swpc_in_t item);
        int unsigned k;
        bit          f;
        swpc_out_t   res;
        k = wlen_model;
        // Out-of-range window lengths clamp to the legal span.
        if (k < 3)
            k = 3;
        if (k > MAX_WINDOW)
            k = MAX_WINDOW;
        // Past MAX_LENGTH the state freezes; a last mark still reports.
        if (n_taken < MAX_LENGTH)
        begin
            // The previous sample's flag settles now that its right neighbor is here.
            if (n_taken >= 2)
            begin
                f = (hist2 < hist1) && (hist1 > item.height);
                peak_flags[FLAG_AW'((n_taken - 1) % MAX_WINDOW)] = f;
                win_count = win_count + f;
            end
            // Drop the flag that slides out of the window interior.
            if (n_taken >= k)
                win_count = win_count - peak_flags[FLAG_AW'((n_taken - k + 1) % MAX_WINDOW)];
            if (n_taken + 1 == k)
            begin
                top_count = win_count;
                top_start = '0;
            end
            else if (n_taken + 1 > k && win_count > top_count)
            begin
                top_count = win_count;
                top_start = 20'(n_taken - k + 1);
            end
            hist2   = hist1;
            hist1   = item.height;
            n_taken = n_taken + 1;
        end
        if (item.last)
        begin
            // A sequence shorter than the window reports what it has, from start 1.
            if (n_taken < k)
            begin
                res.best_parts = win_count + 1'b1;
                res.best_start = START_BITS'(1);
            end
            else
            begin
                res.best_parts = top_count + 1'b1;
                res.best_start = START_BITS'(top_start) + START_BITS'(1);
            end
            expected_best = {expected_best, res};
            clear_sequence();
        end
    endtask

    // Offer one item and hold it until accepted. In burst mode, drop valid
    // for a random gap between bursts.
    task automatic send_item(input logic [HEIGHT_BITS-1:0] h, input logic lst);
        swpc_in_t item;
        item.height = h;
        item.last   = lst;
        if (tx_gaps && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        track_peaks(item);
        items_sent = items_sent + 1;
        if (burst_left != 0)
            burst_left = burst_left - 1;
    endtask

    // Let every expected result arrive, then wait out the pipeline.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_best.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write window_len with the block idle, then read it back.
    task automatic write_window_len(input int unsigned value);
        logic [PDATA_BITS-1:0] wdata;
        settle_idle();
        wdata   = {{(PDATA_BITS - WLEN_BITS){1'b0}}, value[WLEN_BITS-1:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_LEN, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        wlen_model = value[WLEN_BITS-1:0];
        // Keep psel up and go straight into the readback setup cycle.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== wdata)
        begin
            $display("%0t: window_len readback mismatch: expected %0d, actual %0d",
                     $time, wdata, prdata);
            err_count = err_count + 1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: a long hold-off when asked, else a random ready/stall
    // pattern of its own, else always ready.
    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            out_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else if (!rx_stalls)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            if (rx_run == 0)
            begin
                rx_phase = !rx_phase;
                rx_run   = rx_phase ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            else
            begin
                rx_run = rx_run - 1;
            end
            out_ready <= rx_phase;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_best.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual parts %0d start %0d",
                         $time, out_data.best_parts, out_data.best_start);
                err_count = err_count + 1;
            end
            else
            begin
                want = expected_best.pop_front();
                if (out_data.best_parts !== want.best_parts)
                begin
                    $display("%0t: best_parts mismatch: expected %0d, actual %0d",
                             $time, want.best_parts, out_data.best_parts);
                    err_count = err_count + 1;
                end
                if (out_data.best_start !== want.best_start)
                begin
                    $display("%0t: best_start mismatch: expected %0d, actual %0d",
                             $time, want.best_start, out_data.best_start);
                    err_count = err_count + 1;
                end
            end
        end
    end

    // Short hand-picked sequences at the reset window length, then the
    // window length extremes.
    task automatic test_directed();
        // One peak in the middle of an exact window.
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b1);
        // Single sample, and a two-sample sequence: both shorter than the window.
        send_item(32'd7, 1'b1);
        send_item(32'd1, 1'b0);
        send_item(32'd2, 1'b1);
        // Plateau: equal neighbors are not peaks.
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b1);
        // Peak at the top value next to one less, then a later window.
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFE, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h0000_0000, 1'b1);
        // Window length below the minimum acts as three.
        write_window_len(1);
        send_item(32'd1, 1'b0);
        send_item(32'd3, 1'b0);
        send_item(32'd1, 1'b0);
        send_item(32'd3, 1'b0);
        send_item(32'd1, 1'b1);
        // Largest legal window with a short sequence: settled peaks only.
        write_window_len(MAX_WINDOW);
        send_item(32'd0, 1'b0);
        send_item(32'd9, 1'b0);
        send_item(32'd0, 1'b0);
        send_item(32'd9, 1'b0);
        send_item(32'd0, 1'b1);
        // Field maximum acts as the largest window.
        write_window_len((1 << WLEN_BITS) - 1);
        send_item(32'd2, 1'b1);
    endtask

    // Change the window length in the middle of a sequence, both ways.
    task automatic test_mid_sequence_change();
        int i;
        write_window_len(3);
        for (i = 0; i < 6; i++)
            send_item((i % 2) ? 32'd8 : 32'd1, 1'b0);
        write_window_len(5);
        for (i = 0; i < 7; i++)
            send_item($urandom_range(0, 3), i == 6);
        for (i = 0; i < 9; i++)
            send_item((i % 2) ? 32'd8 : 32'd1, 1'b0);
        // Shrinking leaves older flags that are never dropped, so counts run high.
        write_window_len(3);
        for (i = 0; i < 4; i++)
            send_item($urandom_range(0, 3), i == 3);
    endtask

    // One sequence that runs well past a long window, so the count slides.
    task automatic test_full_window();
        int i;
        write_window_len(64);
        for (i = 0; i < 100; i++)
        begin
            if (i % 17 == 0)
                send_item($urandom, 1'b0);
            else
                send_item((i % 2) ? 32'd10 : 32'd0, i == 99);
        end
    endtask

    // Hold the receiver off for a long stretch while offering a run of
    // last items, so the block fills up and stalls its input.
    task automatic test_backpressure();
        int i;
        write_window_len(3);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        rx_hold   = 300;
        for (i = 0; i < 40; i++)
            send_item($urandom, 1'b1);
        // Follow with a few full sequences after the hold has run out.
        for (i = 0; i < 30; i++)
            send_item($urandom_range(0, 3), i % 6 == 5);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // Random sequences of mostly well-formed length and random content.
    task automatic test_random_sequences();
        int unsigned w;
        int unsigned eff;
        int unsigned len;
        int unsigned style;
        int unsigned seq_no;
        int unsigned first_item;
        int unsigned r;
        int          i;
        logic [HEIGHT_BITS-1:0] h;
        first_item = items_sent;
        seq_no     = 0;
        w          = 3;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            if (seq_no % 3 == 0)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    w = $urandom_range(0, 2);
                else if (r == 1)
                    w = $urandom_range(41, (1 << WLEN_BITS) - 1);
                else if (r < 5)
                    w = $urandom_range(9, 40);
                else
                    w = $urandom_range(3, 8);
                write_window_len(w);
                // Mix stretches with and without idling on each side.
                tx_gaps   = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            eff = (w < 3) ? 3 : ((w > MAX_WINDOW) ? MAX_WINDOW : w);
            // Keep big windows to short sequences.
            if (eff > 40)
                len = $urandom_range(1, 40);
            else
                len = $urandom_range(1, 3 * eff + 4);
            style = $urandom_range(0, 3);
            for (i = 0; i < len; i++)
            begin
                case (style)
                    0: h = $urandom_range(0, 3);
                    1: h = $urandom;
                    2:
                    begin
                        case ($urandom_range(0, 3))
                            0: h = 32'h0000_0000;
                            1: h = 32'hFFFF_FFFF;
                            2: h = 32'h7FFF_FFFF;
                            default: h = 32'h8000_0000;
                        endcase
                    end
                    default: h = (i % 2) ? $urandom_range(100, 200) : $urandom_range(0, 100);
                endcase
                send_item(h, i == len - 1);
            end
            seq_no = seq_no + 1;
        end
    endtask

    initial
    begin
        // Drive every input to a known value from time zero.
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        err_count   = 0;
        cycle_count = 0;
        items_sent  = 0;
        burst_left  = 0;
        tx_gaps     = 1'b1;
        rx_stalls   = 1'b1;
        rx_hold     = 0;
        rx_run      = 0;
        rx_phase    = 1'b0;
        wlen_model  = WLEN_RESET;
        clear_sequence();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_mid_sequence_change();
        test_full_window();
        test_backpressure();
        test_random_sequences();

        // Drain the remaining results and let any stray one show up.
        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
